// File: rtl/ccrn_pkg.sv
// Shared types, constants and the exp2 root table for the response normalizer.
`default_nettype none

package ccrn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIN_DEPTH  = 15;
  localparam int ROOT_STEPS = 16;
  localparam logic [12:0] COUNT_CAP = 13'd8191;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_WINDOW = 2'd0;
  localparam logic [1:0] REG_ALPHA       = 2'd1;
  localparam logic [1:0] REG_BIAS        = 2'd2;
  localparam logic [1:0] REG_BETA        = 2'd3;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SUM,
    T_START,
    T_WAIT,
    T_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    N_IDLE,
    N_MUL_HI,
    N_MUL_LO,
    N_BASE,
    N_NORM,
    N_MANT,
    N_LOG,
    N_BETA,
    N_EXP,
    N_GAIN,
    N_MAG,
    N_SHIFT,
    N_SAT,
    N_DONE
  } nrm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } nrm_stat_t;

  typedef logic [ROOT_STEPS:0][31:0] root_tab_t;

  // Q2.30 roots 2^(2^-i); each entry is the floor square root of the one before.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] trial;
    t    = '0;
    t[0] = 32'h8000_0000;
    for (int i = 1; i <= ROOT_STEPS; i++) begin
      v = {32'd0, t[i-1]} << 30;
      r = '0;
      for (int k = 31; k >= 0; k--) begin
        trial = r | (64'd1 << k);
        if (trial * trial <= v) r = trial;
      end
      t[i] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

`default_nettype wire

// File: rtl/cross_channel_response_norm.sv
// Top level of the cross-channel local response normalizer.
`default_nettype none
// Usage: channel samples of one pixel enter on the in_ stream (tdata = signed
// Q8.8 sample, tlast = final channel of the pixel). Normalized values leave on
// the out_ stream (tdata = signed Q8.8 result, tlast = result for the final
// channel of a flushed pixel, i.e. the last result of the pixel).
// The result for channel k leaves once channel k+half_window has arrived; the
// item carrying tlast flushes every pending channel in channel order.
// Each result passes through window summation over 2*half_window+1 taps, the
// shared-multiplier normalizer (log2 by 16 squarings, exp2 by 16 root
// products) and the output register load. The block holds in_tready low until
// all results caused by an accepted item are loaded into the output register.
// A full output register that the receiver stalls simply holds the sequencer
// in its emit step; nothing is dropped. Reset (synchronous, active low)
// restores the register defaults, empties the window and clears the count.
// Configuration is written through cfg_we/cfg_index/cfg_wdata by the user
// only while idle; the block itself does not enforce this.

module cross_channel_response_norm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] norm_value
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  ccrn_pkg::top_state_t st_r, st_nxt;

  logic [2:0]          hw_r;
  logic [31:0]         alpha_r;
  logic [31:0]         bias_r;
  logic [15:0]         beta_r;

  logic signed [15:0]  win_r [ccrn_pkg::WIN_DEPTH];
  logic [12:0]         count_r;
  logic [2:0]          p_r;
  logic [2:0]          stop_r;
  logic [3:0]          j_r;
  logic [34:0]         acc_r;
  logic                last_r;
  logic signed [15:0]  res_r;

  logic                out_tvalid_r;
  logic [15:0]         out_data_r;
  logic                out_last_r;

  logic                accept;
  logic                start;
  logic                out_load;
  logic                out_free;

  logic [12:0]         cnt_nxt;
  logic                has_res;
  logic [2:0]          first;
  logic signed [5:0]   q;
  logic                q_ok;
  logic [3:0]          q_idx;
  logic signed [31:0]  sq;

  ccrn_pkg::nrm_stat_t nrm_stat;
  logic signed [15:0]  nrm_res;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign cnt_nxt  = (count_r == ccrn_pkg::COUNT_CAP) ? count_r : count_r + 13'd1;
  assign has_res  = in_tlast || ({10'd0, hw_r} < cnt_nxt);
  assign first    = ({10'd0, hw_r} < cnt_nxt) ? hw_r : 3'(cnt_nxt - 13'd1);

  // Window position of the current tap; taps outside the pixel read as zero.
  assign q     = $signed({3'd0, p_r}) - $signed({3'd0, hw_r}) + $signed({2'd0, j_r});
  assign q_ok  = !q[5] && (q < 6'sd15) && ({7'd0, q} < count_r);
  assign q_idx = q_ok ? q[3:0] : 4'd0;
  assign sq    = win_r[q_idx] * win_r[q_idx];

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ccrn_pkg::T_IDLE:  if (accept && has_res) st_nxt = ccrn_pkg::T_SUM;
      ccrn_pkg::T_SUM:   if (j_r == {hw_r, 1'b0}) st_nxt = ccrn_pkg::T_START;
      ccrn_pkg::T_START: st_nxt = ccrn_pkg::T_WAIT;
      ccrn_pkg::T_WAIT:  if (nrm_stat.done) st_nxt = ccrn_pkg::T_EMIT;
      ccrn_pkg::T_EMIT: begin
        if (out_free) st_nxt = (p_r == stop_r) ? ccrn_pkg::T_IDLE : ccrn_pkg::T_SUM;
      end
      default:           st_nxt = ccrn_pkg::T_IDLE;
    endcase
  end

  // Handshake and sequencing strobes.
  always_comb begin
    in_tready = (st_r == ccrn_pkg::T_IDLE);
    start     = (st_r == ccrn_pkg::T_START);
    out_load  = (st_r == ccrn_pkg::T_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ccrn_pkg::T_IDLE;
    else        st_r <= st_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r    <= 3'd2;
      alpha_r <= 32'd3355443;
      bias_r  <= 32'd16777216;
      beta_r  <= 16'd3072;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccrn_pkg::REG_HALF_WINDOW: hw_r    <= cfg_wdata[2:0];
        ccrn_pkg::REG_ALPHA:       alpha_r <= cfg_wdata;
        ccrn_pkg::REG_BIAS:        bias_r  <= cfg_wdata;
        ccrn_pkg::REG_BETA:        beta_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Sample window and channel count; cleared after a pixel's final result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ccrn_pkg::WIN_DEPTH; i++) win_r[i] <= '0;
      count_r <= '0;
    end else if (accept) begin
      for (int i = ccrn_pkg::WIN_DEPTH - 1; i > 0; i--) win_r[i] <= win_r[i-1];
      win_r[0] <= $signed(in_tdata);
      count_r  <= cnt_nxt;
    end else if (out_load && (p_r == stop_r) && last_r) begin
      for (int i = 0; i < ccrn_pkg::WIN_DEPTH; i++) win_r[i] <= '0;
      count_r <= '0;
    end
  end

  // Result sequencing: window sum per pending channel.
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_tlast;
      p_r    <= first;
      stop_r <= in_tlast ? 3'd0 : hw_r;
      j_r    <= '0;
      acc_r  <= '0;
    end else if (st_r == ccrn_pkg::T_SUM) begin
      if (q_ok) acc_r <= acc_r + 35'(unsigned'(sq));
      j_r <= j_r + 4'd1;
    end else if (st_r == ccrn_pkg::T_WAIT && nrm_stat.done) begin
      res_r <= nrm_res;
    end else if (out_load && (p_r != stop_r)) begin
      p_r   <= p_r - 3'd1;
      j_r   <= '0;
      acc_r <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
      out_last_r <= last_r && (p_r == 3'd0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  ccrn_norm u_norm (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .x            (win_r[{1'b0, p_r}]),
    .sum          (acc_r),
    .alpha_scaled (alpha_r),
    .bias_q       (bias_r),
    .beta_q       (beta_r),
    .stat         (nrm_stat),
    .result       (nrm_res)
  );

  // The normalizer finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    nrm_stat.done |-> st_r == ccrn_pkg::T_WAIT)
    else $error("normalizer finished outside the wait step");

  // No new item is taken while the normalizer is still working.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !nrm_stat.busy)
    else $error("input ready while normalizer busy");

  // Finishing a pixel's final channel leaves an empty count behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && p_r == stop_r && last_r) |=> count_r == '0)
    else $error("channel count not cleared after pixel end");

endmodule

`default_nettype wire

// File: rtl/ccrn_norm.sv
// Iterative normalizer: x * (bias + alpha*S)^(-beta) through one shared multiplier.
`default_nettype none

module ccrn_norm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [15:0]   x,
  input  wire logic [34:0]          sum,
  input  wire logic [31:0]          alpha_scaled,
  input  wire logic [31:0]          bias_q,
  input  wire logic [15:0]          beta_q,
  output ccrn_pkg::nrm_stat_t       stat,
  output logic signed [15:0]        result
);

  ccrn_pkg::nrm_state_t st_r, st_nxt;

  logic [3:0]          cnt_r;
  logic [51:0]         acc_r;
  logic [63:0]         b_r;
  logic [5:0]          e_r;
  logic [30:0]         m_r;
  logic [15:0]         frac_r;
  logic [39:0]         pb_r;
  logic                lgneg_r;
  logic signed [13:0]  ip_r;
  logic [15:0]         fp_r;
  logic [31:0]         gain_r;
  logic [47:0]         mag_r;
  logic [16:0]         sat_r;
  logic signed [15:0]  res_r;
  logic                neg_r;
  logic signed [15:0]  x_r;
  logic [34:0]         sum_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic [5:0]          sh;
  logic [63:0]         top_bits;
  logic [33:0]         sq;
  logic signed [22:0]  lg;
  logic [22:0]         lg_abs;
  logic signed [29:0]  e16;
  logic [15:0]         x_abs;
  logic signed [14:0]  s_amt;
  logic [14:0]         r_amt;
  logic [63:0]         rnd;
  logic [16:0]         shifted;
  logic [52:0]         base;

  assign sh       = 6'd32 >> cnt_r[2:0];
  assign top_bits = b_r >> (7'd64 - {1'b0, sh});
  assign sq       = mul_p[63:30];
  assign lg       = {($signed({1'b0, e_r}) - 7'sd24), frac_r};
  assign lg_abs   = lg[22] ? 23'(-lg) : 23'(lg);
  assign x_abs    = x_r[15] ? 16'(-x_r) : 16'(x_r);
  assign base     = 53'(bias_q) + 53'(acc_r);

  always_comb begin
    if (lgneg_r) e16 = $signed({2'b0, pb_r[39:12]});
    else         e16 = -$signed({2'b0, 28'((pb_r + 40'd4095) >> 12)});
  end

  // Final scaling by 2^(ip-30), clamped to 32768 so saturation stays exact.
  always_comb begin
    s_amt   = 15'(ip_r) - 15'sd30;
    r_amt   = 15'(-s_amt);
    rnd     = '0;
    shifted = '0;
    if (mag_r == '0) begin
      shifted = '0;
    end else if (!s_amt[14]) begin
      if (s_amt >= 15'sd16) shifted = 17'd32768;
      else if (mag_r > (48'd32768 >> s_amt[3:0])) shifted = 17'd32768;
      else shifted = 17'(mag_r << s_amt[3:0]);
    end else if (r_amt >= 15'd63) begin
      shifted = '0;
    end else begin
      rnd = ({16'd0, mag_r} + (64'd1 << (r_amt[5:0] - 6'd1))) >> r_amt[5:0];
      shifted = (rnd > 64'd32768) ? 17'd32768 : rnd[16:0];
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ccrn_pkg::N_IDLE:   if (start) st_nxt = ccrn_pkg::N_MUL_HI;
      ccrn_pkg::N_MUL_HI: st_nxt = ccrn_pkg::N_MUL_LO;
      ccrn_pkg::N_MUL_LO: st_nxt = ccrn_pkg::N_BASE;
      ccrn_pkg::N_BASE:   st_nxt = ccrn_pkg::N_NORM;
      ccrn_pkg::N_NORM:   if (cnt_r == 4'd5) st_nxt = ccrn_pkg::N_MANT;
      ccrn_pkg::N_MANT:   st_nxt = ccrn_pkg::N_LOG;
      ccrn_pkg::N_LOG:    if (cnt_r == 4'd15) st_nxt = ccrn_pkg::N_BETA;
      ccrn_pkg::N_BETA:   st_nxt = ccrn_pkg::N_EXP;
      ccrn_pkg::N_EXP:    st_nxt = ccrn_pkg::N_GAIN;
      ccrn_pkg::N_GAIN:   if (cnt_r == 4'd15) st_nxt = ccrn_pkg::N_MAG;
      ccrn_pkg::N_MAG:    st_nxt = ccrn_pkg::N_SHIFT;
      ccrn_pkg::N_SHIFT:  st_nxt = ccrn_pkg::N_SAT;
      ccrn_pkg::N_SAT:    st_nxt = ccrn_pkg::N_DONE;
      ccrn_pkg::N_DONE:   st_nxt = ccrn_pkg::N_IDLE;
      default:            st_nxt = ccrn_pkg::N_IDLE;
    endcase
  end

  // Multiplier operands and status.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    stat.busy = (st_r != ccrn_pkg::N_IDLE);
    stat.done = (st_r == ccrn_pkg::N_DONE);
    unique case (st_r)
      ccrn_pkg::N_MUL_HI: begin mul_a = alpha_scaled; mul_b = 32'(sum_r[34:16]); end
      ccrn_pkg::N_MUL_LO: begin mul_a = alpha_scaled; mul_b = 32'(sum_r[15:0]);  end
      ccrn_pkg::N_LOG:    begin mul_a = 32'(m_r);     mul_b = 32'(m_r);          end
      ccrn_pkg::N_BETA:   begin mul_a = 32'(beta_q);  mul_b = 32'(lg_abs);       end
      ccrn_pkg::N_GAIN: begin
        mul_a = gain_r;
        mul_b = ccrn_pkg::ROOT_TAB[5'(cnt_r) + 5'd1];
      end
      ccrn_pkg::N_MAG:    begin mul_a = 32'(x_abs);   mul_b = gain_r;            end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ccrn_pkg::N_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ccrn_pkg::N_IDLE: begin
        x_r   <= x;
        sum_r <= sum;
        neg_r <= x[15];
      end
      ccrn_pkg::N_MUL_HI: acc_r <= mul_p[51:0];
      ccrn_pkg::N_MUL_LO: acc_r <= acc_r + 52'(mul_p[63:16]);
      ccrn_pkg::N_BASE: begin
        b_r   <= (base == '0) ? 64'd1 : 64'(base);
        e_r   <= 6'd63;
        cnt_r <= '0;
      end
      ccrn_pkg::N_NORM: begin
        if (top_bits == '0) begin
          b_r <= b_r << sh;
          e_r <= e_r - sh;
        end
        cnt_r <= cnt_r + 4'd1;
      end
      ccrn_pkg::N_MANT: begin
        m_r    <= b_r[63:33];
        frac_r <= '0;
        cnt_r  <= '0;
      end
      ccrn_pkg::N_LOG: begin
        if (sq[31]) begin
          m_r    <= sq[31:1];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= sq[30:0];
          frac_r <= {frac_r[14:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      ccrn_pkg::N_BETA: begin
        pb_r    <= mul_p[39:0];
        lgneg_r <= lg[22];
      end
      ccrn_pkg::N_EXP: begin
        ip_r   <= 14'(e16 >>> 16);
        fp_r   <= e16[15:0];
        gain_r <= 32'h4000_0000;
        cnt_r  <= '0;
      end
      ccrn_pkg::N_GAIN: begin
        if (fp_r[4'd15 - cnt_r]) gain_r <= mul_p[61:30];
        cnt_r <= cnt_r + 4'd1;
      end
      ccrn_pkg::N_MAG:   mag_r <= mul_p[47:0];
      ccrn_pkg::N_SHIFT: sat_r <= shifted;
      ccrn_pkg::N_SAT: begin
        if (neg_r) res_r <= 16'(-$signed({1'b0, sat_r}));
        else       res_r <= (sat_r == 17'd32768) ? 16'sd32767 : $signed(sat_r[15:0]);
      end
      default: ;
    endcase
  end

  assign result = res_r;

endmodule

`default_nettype wire
